/* sv/tccb_pkg.sv */
// Shared constants for the text console cell buffer.
package tccb_pkg;

  localparam int unsigned MAX_ROWS_DEF = 32;
  localparam int unsigned MAX_COLS_DEF = 64;

  localparam int ROWS_W = 6;   // rows_in_use register
  localparam int COLS_W = 7;   // cols_in_use register, cursor column
  localparam int CH_W   = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 6;
  localparam int CROW_W = 5;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CH_W-1:0] CH_BS    = 8'd8;
  localparam logic [CH_W-1:0] CH_LF    = 8'd10;
  localparam logic [CH_W-1:0] CH_FF    = 8'd12;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [ROWS_W-1:0] ROWS_RST = 6'd32;
  localparam logic [COLS_W-1:0] COLS_RST = 7'd64;

endpackage

/* sv/tccb_ram.sv */
// Single-port-write, single-port-read synchronous RAM for the cell store.
module tccb_ram #(
  parameter int unsigned DEPTH = tccb_pkg::MAX_ROWS_DEF * tccb_pkg::MAX_COLS_DEF,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = tccb_pkg::CH_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/text_console_cell_buffer_top.sv */
// Text console cell buffer: a MAX_ROWS x MAX_COLS byte store with a cursor.
// Put transfers (cmd 0) write one character: newline moves to column 0 of the
// next row or scrolls at the last row, backspace steps left (not past column
// 0) and writes a space, form feed blanks the screen and homes the cursor, any
// other byte wraps first when the column equals the width, is stored, and the
// column advances. Read transfers (cmd 1) return one cell (0 outside the
// screen). Every item yields one result transfer carrying the cursor after it.
// Scrolling moves a top-row pointer around the store as a ring and blanks the
// new bottom row. An ordinary put, a newline without scroll and a backspace
// are done in the execute state; a read passes through a further state for
// the registered RAM output; a scroll then blanks the row cell by cell (and
// stores the character afterwards when a wrap caused it); form feed blanks
// the whole store cell by cell. After reset the block sweeps zeros through the
// whole store before it takes the first item; register writes are taken
// during the sweep. When the row count is shrunk to the top-row pointer or
// below, the next item first subtracts the row count from that pointer until
// it lies inside the ring.
module text_console_cell_buffer_top #(
  parameter int unsigned MAX_ROWS = tccb_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = tccb_pkg::MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tccb_pkg::APB_AW-1:0] paddr,
  input  logic [tccb_pkg::APB_DW-1:0] pwdata,
  output logic [tccb_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [tccb_pkg::CH_W-1:0]   ch_i,
  input  logic [tccb_pkg::RROW_W-1:0] read_row_i,
  input  logic [tccb_pkg::RCOL_W-1:0] read_col_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tccb_pkg::CH_W-1:0]   read_char_o,
  output logic [tccb_pkg::CROW_W-1:0] cursor_row_o,
  output logic [tccb_pkg::COLS_W-1:0] cursor_col_o,
  output logic                        scrolled_o,
  output logic                        cleared_o
);

  import tccb_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    S_INIT    = 7'b0000001,  // zero sweep after reset
    S_IDLE    = 7'b0000010,
    S_EXEC    = 7'b0000100,  // normalize geometry, act on item
    S_RDATA   = 7'b0001000,
    S_ROWCLR  = 7'b0010000,  // blank new bottom row after scroll
    S_PUT     = 7'b0100000,  // store char deferred behind a row blank
    S_FULLCLR = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COLS) begin
        cols_q <= pwdata[COLS_W-1:0];
      end else begin
        rows_q <= pwdata[ROWS_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COLS) begin
      prdata = {{(APB_DW-COLS_W){1'b0}}, cols_q};
    end else begin
      prdata = {{(APB_DW-ROWS_W){1'b0}}, rows_q};
    end
  end

  // effective geometry, limited to 1..MAX
  logic [ROWS_W-1:0] nrows;
  logic [COLS_W-1:0] ncols;

  always_comb begin
    if (rows_q == '0) begin
      nrows = ROWS_W'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nrows = ROWS_W'(MAX_ROWS);
    end else begin
      nrows = rows_q;
    end
    if (cols_q == '0) begin
      ncols = COLS_W'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      ncols = COLS_W'(MAX_COLS);
    end else begin
      ncols = cols_q;
    end
  end

  // ---------------------------------------------------------------------
  // Cursor state and held item
  // ---------------------------------------------------------------------
  logic [ROWS_W-1:0] row_q, row_d;
  logic [COLS_W-1:0] col_q, col_d;
  logic [ROWS_W-1:0] top_q, top_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     base_q, base_d;
  logic              pend_q, pend_d;
  logic              hit_q, hit_d;
  logic              scr_q, scr_d;
  logic              clr_q, clr_d;

  logic              cmd_q;
  logic [CH_W-1:0]   ch_q;
  logic [RROW_W-1:0] rr_q;
  logic [RCOL_W-1:0] rc_q;
  logic              in_take;

  // cursor pulled back inside a possibly shrunk screen
  logic [ROWS_W-1:0] row_c;
  logic [COLS_W-1:0] col_c;
  logic [COLS_W-1:0] bs_col;
  logic              nl_scroll;
  logic [ROWS_W-1:0] top_inc;
  logic              rd_hit;
  logic              wrap;

  assign row_c     = (row_q >= nrows) ? (nrows - ROWS_W'(1)) : row_q;
  assign col_c     = (col_q > ncols) ? ncols : col_q;
  assign bs_col    = (col_c == '0) ? '0 : (col_c - COLS_W'(1));
  assign nl_scroll = ((ROWS_W+1)'(row_c) + (ROWS_W+1)'(1)) >= (ROWS_W+1)'(nrows);
  assign top_inc   = (((ROWS_W+1)'(top_q) + (ROWS_W+1)'(1)) >= (ROWS_W+1)'(nrows)) ?
                     '0 : (top_q + ROWS_W'(1));
  assign rd_hit    = (ROWS_W'(rr_q) < nrows) && (COLS_W'(rc_q) < ncols);
  assign wrap      = (col_c >= ncols);

  // cell address: displayed row/col to a store entry through the ring
  logic [ROWS_W-1:0] acc_row;
  logic [COLS_W-1:0] acc_col;
  logic [ROWS_W:0]   ring_sum;
  logic [ROWS_W-1:0] phys_row;
  logic [AW-1:0]     acc_addr;
  logic [AW-1:0]     top_base;

  always_comb begin
    if (cmd_q == CMD_READ) begin
      acc_row = ROWS_W'(rr_q);
      acc_col = COLS_W'(rc_q);
    end else if (ch_q == CH_BS) begin
      acc_row = row_c;
      acc_col = bs_col;
    end else if (wrap) begin
      acc_row = nl_scroll ? row_c : (row_c + ROWS_W'(1));
      acc_col = '0;
    end else begin
      acc_row = row_c;
      acc_col = col_c;
    end
  end

  always_comb begin
    ring_sum = (ROWS_W+1)'(top_q) + (ROWS_W+1)'(acc_row);
    if (ring_sum >= (ROWS_W+1)'(nrows)) begin
      ring_sum = ring_sum - (ROWS_W+1)'(nrows);
    end
    phys_row = ring_sum[ROWS_W-1:0];
    acc_addr = AW'(AW'(phys_row) * AW'(MAX_COLS)) + AW'(acc_col);
  end

  // old top row is the row that becomes the bottom on a scroll
  assign top_base = AW'(AW'(top_q) * AW'(MAX_COLS));

  // ---------------------------------------------------------------------
  // Cell RAM
  // ---------------------------------------------------------------------
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [CH_W-1:0] mem_wdata;
  logic            mem_re;
  logic [CH_W-1:0] mem_rdata;

  tccb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CH_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (acc_addr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic out_valid_q;
  logic emit;

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    top_d     = top_q;
    cnt_d     = cnt_q;
    base_d    = base_q;
    pend_d    = pend_q;
    hit_d     = hit_q;
    scr_d     = scr_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = acc_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    emit      = 1'b0;
    in_stall_o = 1'b1;
    in_take   = 1'b0;

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        // output slot is free or drains at this edge
        in_stall_o = out_valid_q & out_stall_i;
        if (in_valid_i && !in_stall_o) begin
          in_take = 1'b1;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        row_d = row_c;
        col_d = col_c;
        scr_d = 1'b0;
        clr_d = 1'b0;
        if ((ROWS_W+1)'(top_q) >= (ROWS_W+1)'(nrows)) begin
          // reduce top pointer into the ring, one subtract per cycle
          top_d = top_q - nrows;
        end else if (cmd_q == CMD_READ) begin
          hit_d   = rd_hit;
          mem_re  = 1'b1;
          state_d = S_RDATA;
        end else begin
          case (ch_q)
            CH_LF: begin
              col_d = '0;
              if (nl_scroll) begin
                top_d   = top_inc;
                row_d   = nrows - ROWS_W'(1);
                base_d  = top_base;
                cnt_d   = '0;
                pend_d  = 1'b0;
                scr_d   = 1'b1;
                state_d = S_ROWCLR;
              end else begin
                row_d   = row_c + ROWS_W'(1);
                emit    = 1'b1;
                state_d = S_IDLE;
              end
            end
            CH_BS: begin
              col_d     = bs_col;
              mem_we    = 1'b1;
              mem_wdata = CH_SPACE;
              emit      = 1'b1;
              state_d   = S_IDLE;
            end
            CH_FF: begin
              top_d   = '0;
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              clr_d   = 1'b1;
              state_d = S_FULLCLR;
            end
            default: begin
              if (wrap && nl_scroll) begin
                // blank the row first, then store at its column 0
                top_d   = top_inc;
                row_d   = nrows - ROWS_W'(1);
                col_d   = COLS_W'(1);
                base_d  = top_base;
                cnt_d   = '0;
                pend_d  = 1'b1;
                scr_d   = 1'b1;
                state_d = S_ROWCLR;
              end else begin
                if (wrap) begin
                  row_d = row_c + ROWS_W'(1);
                  col_d = COLS_W'(1);
                end else begin
                  col_d = col_c + COLS_W'(1);
                end
                mem_we    = 1'b1;
                mem_wdata = ch_q;
                emit      = 1'b1;
                state_d   = S_IDLE;
              end
            end
          endcase
        end
      end

      S_RDATA: begin
        emit    = 1'b1;
        state_d = S_IDLE;
      end

      S_ROWCLR: begin
        mem_we    = 1'b1;
        mem_waddr = base_q + cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(MAX_COLS - 1)) begin
          cnt_d = '0;
          if (pend_q) begin
            state_d = S_PUT;
          end else begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = base_q;
        mem_wdata = ch_q;
        emit      = 1'b1;
        state_d   = S_IDLE;
      end

      S_FULLCLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          cnt_d   = '0;
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      cnt_q   <= '0;
      base_q  <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      scr_q   <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      scr_q   <= scr_d;
      clr_q   <= clr_d;
    end
  end

  // held item
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_i;
      ch_q  <= ch_i;
      rr_q  <= read_row_i;
      rc_q  <= read_col_i;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [CH_W-1:0]   rchar_q;
  logic [CROW_W-1:0] crow_q;
  logic [COLS_W-1:0] ccol_q;
  logic              oscr_q;
  logic              oclr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rchar_q <= ((state_q == S_RDATA) && hit_q) ? mem_rdata : '0;
      crow_q  <= row_d[CROW_W-1:0];
      ccol_q  <= col_d;
      oscr_q  <= scr_d;
      oclr_q  <= clr_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_char_o  = rchar_q;
  assign cursor_row_o = crow_q;
  assign cursor_col_o = ccol_q;
  assign scrolled_o   = oscr_q;
  assign cleared_o    = oclr_q;

endmodule
